@@ hdl/emrs_pkg.sv @@
// Shared types and constants for the energy meter report scheduler.
// Holds field widths, register reset values, reciprocal constants and the
// structs passed from the scaling pipeline and the register file to the scheduler.
package emrs_pkg;

	// Field widths
	localparam int RAW_W   = 24;
	localparam int VOLTS_W = 16;
	localparam int AMPS_W  = 16;
	localparam int WATTS_W = 28;
	localparam int EMWH_W  = 32;
	localparam int EINC_W  = 23;   // largest increment is 16777215*5/18 = 4660337
	localparam int SECS_W  = 16;
	localparam int REG_W   = 16;
	localparam int VQ_W    = 18;   // raw_voltage/100 fits in 18 bits

	// APB register file
	localparam int APB_DW  = 32;
	localparam int PADDR_W = 5;

	typedef enum logic [2:0] {
		REG_VOLT_THR      = 3'd0,
		REG_AMP_THR       = 3'd1,
		REG_WATT_THR      = 3'd2,
		REG_MWH_THR       = 3'd3,
		REG_MIN_REPORT    = 3'd4,
		REG_MAX_REPORT    = 3'd5,
		REG_SAVE_INTERVAL = 3'd6
	} reg_idx_t;

	localparam logic [REG_W-1:0] VOLT_THR_RST      = 16'd30;
	localparam logic [REG_W-1:0] AMP_THR_RST       = 16'd2000;
	localparam logic [REG_W-1:0] WATT_THR_RST      = 16'd20;
	localparam logic [REG_W-1:0] MWH_THR_RST       = 16'd2000;
	localparam logic [REG_W-1:0] MIN_REPORT_RST    = 16'd10;
	localparam logic [REG_W-1:0] MAX_REPORT_RST    = 16'd60;
	localparam logic [REG_W-1:0] SAVE_INTERVAL_RST = 16'd600;

	localparam logic [SECS_W-1:0] SECS_MAX = 16'hFFFF;

	// Exact constant division: floor(x*a/d) == (x*ceil(2^s*a/d)) >> s for the
	// full input range, with s chosen so that 2^s > x_max*d.
	// raw_voltage/100
	localparam int               V100_SHIFT = 31;
	localparam int               V100_PW    = 49;
	localparam logic [24:0]      V100_RECIP = 25'd21474837;
	// q*1087/5000, same as q*21740/100000
	localparam int               VOLT_SHIFT = 31;
	localparam int               VOLT_PW    = 47;
	localparam logic [28:0]      VOLT_RECIP = 29'd466862946;
	// raw_current*9/6250, same as raw_current*144/100000
	localparam int               AMP_SHIFT  = 37;
	localparam int               AMP_PW     = 52;
	localparam logic [27:0]      AMP_RECIP  = 28'd197912093;
	// raw_energy*5/18, same as raw_energy*100/360
	localparam int               EN_SHIFT   = 29;
	localparam int               EN_PW      = 52;
	localparam logic [27:0]      EN_RECIP   = 28'd149130809;

	// Scaled values of one item, leaving the scaling pipeline
	typedef struct packed {
		logic [VOLTS_W-1:0] volts;
		logic [AMPS_W-1:0]  amps;
		logic [WATTS_W-1:0] watts;
		logic [EINC_W-1:0]  e_inc;
	} scaled_t;

	// Configuration registers as seen by the scheduler
	typedef struct packed {
		logic [REG_W-1:0] volt_thr;
		logic [REG_W-1:0] amp_thr;
		logic [REG_W-1:0] watt_thr;
		logic [REG_W-1:0] mwh_thr;
		logic [REG_W-1:0] min_report_secs;
		logic [REG_W-1:0] max_report_secs;
		logic [REG_W-1:0] save_interval_secs;
	} cfg_t;

endpackage

@@ hdl/emrs_if.sv @@
// Valid/ready channel interfaces for meter readings and scheduler results.
// Depends on emrs_pkg for field widths.
interface emrs_in_if;
	logic                          valid;
	logic                          ready;
	logic [emrs_pkg::RAW_W-1:0]    raw_voltage;
	logic [emrs_pkg::RAW_W-1:0]    raw_current;
	logic [emrs_pkg::RAW_W-1:0]    raw_power;
	logic [emrs_pkg::RAW_W-1:0]    raw_energy;

	modport source (output valid, raw_voltage, raw_current, raw_power, raw_energy,
		input ready);
	modport sink (input valid, raw_voltage, raw_current, raw_power, raw_energy,
		output ready);
endinterface

interface emrs_out_if;
	logic                          valid;
	logic                          ready;
	logic [emrs_pkg::VOLTS_W-1:0]  volts_deci;
	logic [emrs_pkg::AMPS_W-1:0]   amps_milli;
	logic [emrs_pkg::WATTS_W-1:0]  watts_deci;
	logic [emrs_pkg::EMWH_W-1:0]   energy_mwh;
	logic                          report_now;
	logic                          save_now;

	modport source (output valid, volts_deci, amps_milli, watts_deci, energy_mwh,
		report_now, save_now, input ready);
	modport sink (input valid, volts_deci, amps_milli, watts_deci, energy_mwh,
		report_now, save_now, output ready);
endinterface

@@ hdl/emrs_scale.sv @@
// Three-stage scaling pipeline: raw readings to decivolts, milliamps,
// deciwatts and the milliwatt-hour increment. Depends on emrs_pkg, emrs_in_if.
module emrs_scale (
	input  logic              clk,
	input  logic              arst_n,
	emrs_in_if.sink           reading,
	output logic              s_valid,
	input  logic              s_ready,
	output emrs_pkg::scaled_t s_data
);

	logic                             valid_s1, valid_s2, valid_s3;
	logic                             rdy1, rdy2, rdy3;
	logic [emrs_pkg::RAW_W-1:0]       raw_v_s1, raw_c_s1, raw_p_s1, raw_e_s1;
	logic [emrs_pkg::VQ_W-1:0]        vq_s2;
	logic [emrs_pkg::AMPS_W-1:0]      amps_s2, amps_s3;
	logic [emrs_pkg::WATTS_W-1:0]     watts_s2, watts_s3;
	logic [emrs_pkg::EINC_W-1:0]      einc_s2, einc_s3;
	logic [emrs_pkg::VOLTS_W-1:0]     volts_s3;
	logic [emrs_pkg::V100_PW-1:0]     v100_prod;
	logic [emrs_pkg::AMP_PW-1:0]      amp_prod;
	logic [emrs_pkg::EN_PW-1:0]       en_prod;
	logic [emrs_pkg::VOLT_PW-1:0]     volt_prod;

	// Each stage takes new data when it is empty or its successor takes its own
	assign rdy3          = !valid_s3 || s_ready;
	assign rdy2          = !valid_s2 || rdy3;
	assign rdy1          = !valid_s1 || rdy2;
	assign reading.ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= reading.valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	// Stage 1: capture the raw readings
	always_ff @(posedge clk) begin
		if (rdy1 && reading.valid) begin
			raw_v_s1 <= reading.raw_voltage;
			raw_c_s1 <= reading.raw_current;
			raw_p_s1 <= reading.raw_power;
			raw_e_s1 <= reading.raw_energy;
		end
	end

	// Stage 2: reciprocal products for voltage/100, current and energy; power times ten
	assign v100_prod = emrs_pkg::V100_PW'(raw_v_s1) * emrs_pkg::V100_PW'(emrs_pkg::V100_RECIP);
	assign amp_prod  = emrs_pkg::AMP_PW'(raw_c_s1) * emrs_pkg::AMP_PW'(emrs_pkg::AMP_RECIP);
	assign en_prod   = emrs_pkg::EN_PW'(raw_e_s1) * emrs_pkg::EN_PW'(emrs_pkg::EN_RECIP);

	always_ff @(posedge clk) begin
		if (rdy2 && valid_s1) begin
			vq_s2    <= v100_prod[emrs_pkg::V100_SHIFT +: emrs_pkg::VQ_W];
			amps_s2  <= emrs_pkg::AMPS_W'(amp_prod[emrs_pkg::AMP_PW-1:emrs_pkg::AMP_SHIFT]);
			einc_s2  <= en_prod[emrs_pkg::EN_SHIFT +: emrs_pkg::EINC_W];
			// times ten as 8x + 2x
			watts_s2 <= emrs_pkg::WATTS_W'({raw_p_s1, 3'b000})
				+ emrs_pkg::WATTS_W'({raw_p_s1, 1'b0});
		end
	end

	// Stage 3: second voltage scaling step
	assign volt_prod = emrs_pkg::VOLT_PW'(vq_s2) * emrs_pkg::VOLT_PW'(emrs_pkg::VOLT_RECIP);

	always_ff @(posedge clk) begin
		if (rdy3 && valid_s2) begin
			volts_s3 <= volt_prod[emrs_pkg::VOLT_SHIFT +: emrs_pkg::VOLTS_W];
			amps_s3  <= amps_s2;
			watts_s3 <= watts_s2;
			einc_s3  <= einc_s2;
		end
	end

	assign s_valid      = valid_s3;
	assign s_data.volts = volts_s3;
	assign s_data.amps  = amps_s3;
	assign s_data.watts = watts_s3;
	assign s_data.e_inc = einc_s3;

endmodule

@@ hdl/emrs_sched.sv @@
// Report and save scheduler: change detection, energy total, second counters
// and the result register. Depends on emrs_pkg and emrs_out_if.
module emrs_sched (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_valid,
	output logic              s_ready,
	input  emrs_pkg::scaled_t s_data,
	input  emrs_pkg::cfg_t    cfg,
	emrs_out_if.source        result
);

	logic                            out_vld_q;
	logic                            move;
	logic [emrs_pkg::VOLTS_W-1:0]    volts_q, prev_volts_q, dv;
	logic [emrs_pkg::AMPS_W-1:0]     amps_q, prev_amps_q, da;
	logic [emrs_pkg::WATTS_W-1:0]    watts_q, prev_watts_q, dw;
	logic [emrs_pkg::EMWH_W-1:0]     energy_total_q, energy_nxt;
	logic                            report_q, save_q;
	logic                            pending_q, pend;
	logic [emrs_pkg::SECS_W-1:0]     secs_rpt_q, secs_save_q, rs, ss;
	logic                            report, save;

	function automatic logic [emrs_pkg::SECS_W-1:0] sat_inc(
		input logic [emrs_pkg::SECS_W-1:0] v);
		return (v == emrs_pkg::SECS_MAX) ? v : v + emrs_pkg::SECS_W'(1);
	endfunction

	// Output register frees when empty or taken
	assign s_ready = !out_vld_q || result.ready;
	assign move    = s_valid && s_ready;

	// Absolute differences against the previous item
	assign dv = (s_data.volts >= prev_volts_q) ? s_data.volts - prev_volts_q
		: prev_volts_q - s_data.volts;
	assign da = (s_data.amps >= prev_amps_q) ? s_data.amps - prev_amps_q
		: prev_amps_q - s_data.amps;
	assign dw = (s_data.watts >= prev_watts_q) ? s_data.watts - prev_watts_q
		: prev_watts_q - s_data.watts;

	// The previous energy always equals the old total, so its change is the increment
	assign energy_nxt = energy_total_q + emrs_pkg::EMWH_W'(s_data.e_inc);

	assign pend = pending_q
		|| (dv > cfg.volt_thr)
		|| (da > cfg.amp_thr)
		|| (dw > emrs_pkg::WATTS_W'(cfg.watt_thr))
		|| (s_data.e_inc > emrs_pkg::EINC_W'(cfg.mwh_thr));

	// Advance both second counters, then decide
	assign rs     = sat_inc(secs_rpt_q);
	assign ss     = sat_inc(secs_save_q);
	assign report = (pend && (rs >= cfg.min_report_secs)) || (rs >= cfg.max_report_secs);
	assign save   = ss > cfg.save_interval_secs;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q      <= 1'b0;
			prev_volts_q   <= '0;
			prev_amps_q    <= '0;
			prev_watts_q   <= '0;
			energy_total_q <= '0;
			pending_q      <= 1'b0;
			secs_rpt_q     <= '0;
			secs_save_q    <= '0;
		end else begin
			if (s_ready) out_vld_q <= s_valid;
			if (move) begin
				prev_volts_q   <= s_data.volts;
				prev_amps_q    <= s_data.amps;
				prev_watts_q   <= s_data.watts;
				energy_total_q <= energy_nxt;
				pending_q      <= report ? 1'b0 : pend;
				secs_rpt_q     <= report ? '0 : rs;
				secs_save_q    <= save ? '0 : ss;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (move) begin
			volts_q  <= s_data.volts;
			amps_q   <= s_data.amps;
			watts_q  <= s_data.watts;
			report_q <= report;
			save_q   <= save;
		end
	end

	assign result.valid      = out_vld_q;
	assign result.volts_deci = volts_q;
	assign result.amps_milli = amps_q;
	assign result.watts_deci = watts_q;
	assign result.energy_mwh = energy_total_q;
	assign result.report_now = report_q;
	assign result.save_now   = save_q;

endmodule

@@ hdl/energy_meter_report_scheduler_unit.sv @@
// Top level of the energy meter report scheduler: APB register file plus the
// scaling pipeline and scheduler. Depends on emrs_pkg, emrs_if, emrs_scale, emrs_sched.
//
// Usage:
//  - reading: one transfer per metering second carries the raw voltage, current,
//    power and per-second energy. result: one transfer per reading carries the
//    scaled values, the running milliwatt-hour total and the report/save flags.
//  - Path: a reading passes the three scaling stages, then the result register,
//    before its result is presented.
//  - Throughput: one reading per cycle without stalls; pipeline holds up to four items.
//    reading.ready stays high while any stage, result register included, is free.
//  - When the receiver stalls, the result holds in its register and the stages
//    behind it fill; reading.ready drops only when all four are occupied.
//  - Reset (arst_n low) empties the pipeline, clears the energy total, the change
//    flag and both second counters, and loads the register defaults.
//  - Registers at byte address 4*i: voltage, current, power and energy deltas,
//    minimum and maximum report seconds, save interval. Write them only while
//    no reading is in flight. Zero-wait APB, reads return the register value.
module energy_meter_report_scheduler_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	emrs_in_if.sink                        reading,
	emrs_out_if.source                     result,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [emrs_pkg::PADDR_W-1:0]   paddr,
	input  logic [emrs_pkg::APB_DW-1:0]    pwdata,
	output logic [emrs_pkg::APB_DW-1:0]    prdata,
	output logic                           pready
);

	emrs_pkg::cfg_t     cfg_q;
	emrs_pkg::reg_idx_t reg_idx;
	emrs_pkg::scaled_t  s_data;
	logic               s_valid, s_ready;
	logic               wr_en;

	assign pready  = 1'b1;
	assign reg_idx = emrs_pkg::reg_idx_t'(paddr[emrs_pkg::PADDR_W-1:2]);
	assign wr_en   = psel && penable && pwrite && pready;

	// Register writes; unused addresses drop the write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.volt_thr           <= emrs_pkg::VOLT_THR_RST;
			cfg_q.amp_thr            <= emrs_pkg::AMP_THR_RST;
			cfg_q.watt_thr           <= emrs_pkg::WATT_THR_RST;
			cfg_q.mwh_thr            <= emrs_pkg::MWH_THR_RST;
			cfg_q.min_report_secs    <= emrs_pkg::MIN_REPORT_RST;
			cfg_q.max_report_secs    <= emrs_pkg::MAX_REPORT_RST;
			cfg_q.save_interval_secs <= emrs_pkg::SAVE_INTERVAL_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				emrs_pkg::REG_VOLT_THR:      cfg_q.volt_thr           <= pwdata[15:0];
				emrs_pkg::REG_AMP_THR:       cfg_q.amp_thr            <= pwdata[15:0];
				emrs_pkg::REG_WATT_THR:      cfg_q.watt_thr           <= pwdata[15:0];
				emrs_pkg::REG_MWH_THR:       cfg_q.mwh_thr            <= pwdata[15:0];
				emrs_pkg::REG_MIN_REPORT:    cfg_q.min_report_secs    <= pwdata[15:0];
				emrs_pkg::REG_MAX_REPORT:    cfg_q.max_report_secs    <= pwdata[15:0];
				emrs_pkg::REG_SAVE_INTERVAL: cfg_q.save_interval_secs <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// Register reads
	always_comb begin
		unique case (reg_idx)
			emrs_pkg::REG_VOLT_THR:      prdata = emrs_pkg::APB_DW'(cfg_q.volt_thr);
			emrs_pkg::REG_AMP_THR:       prdata = emrs_pkg::APB_DW'(cfg_q.amp_thr);
			emrs_pkg::REG_WATT_THR:      prdata = emrs_pkg::APB_DW'(cfg_q.watt_thr);
			emrs_pkg::REG_MWH_THR:       prdata = emrs_pkg::APB_DW'(cfg_q.mwh_thr);
			emrs_pkg::REG_MIN_REPORT:    prdata = emrs_pkg::APB_DW'(cfg_q.min_report_secs);
			emrs_pkg::REG_MAX_REPORT:    prdata = emrs_pkg::APB_DW'(cfg_q.max_report_secs);
			emrs_pkg::REG_SAVE_INTERVAL: prdata = emrs_pkg::APB_DW'(cfg_q.save_interval_secs);
			default:                     prdata = '0;
		endcase
	end

	emrs_scale u_scale (
		.clk     (clk),
		.arst_n  (arst_n),
		.reading (reading),
		.s_valid (s_valid),
		.s_ready (s_ready),
		.s_data  (s_data)
	);

	emrs_sched u_sched (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_valid (s_valid),
		.s_ready (s_ready),
		.s_data  (s_data),
		.cfg     (cfg_q),
		.result  (result)
	);

endmodule

@@ hdl/emrs_checker.sv @@
// Port-level checks for the energy meter report scheduler, bound to the top.
// Depends on emrs_pkg and the top level's port names.
module emrs_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [emrs_pkg::VOLTS_W-1:0]   volts_deci,
	input logic [emrs_pkg::AMPS_W-1:0]    amps_milli,
	input logic [emrs_pkg::WATTS_W-1:0]   watts_deci,
	input logic [emrs_pkg::EMWH_W-1:0]    energy_mwh,
	input logic                           report_now,
	input logic                           save_now
);

	localparam logic [emrs_pkg::EMWH_W-1:0] EINC_MAX = 32'd4660337;

	logic                          in_xfer, out_xfer;
	logic [2:0]                    inflight_q;
	logic                          seen_q;
	logic [emrs_pkg::EMWH_W-1:0]   last_e_q, e_step;

	assign in_xfer  = in_valid && in_ready;
	assign out_xfer = out_valid && out_ready;
	assign e_step   = energy_mwh - last_e_q;

	// Track items in flight and the last delivered energy total
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inflight_q <= '0;
			seen_q     <= 1'b0;
			last_e_q   <= '0;
		end else begin
			inflight_q <= inflight_q + 3'(in_xfer) - 3'(out_xfer);
			if (out_xfer) begin
				seen_q   <= 1'b1;
				last_e_q <= energy_mwh;
			end
		end
	end

	// Hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(volts_deci)
			&& $stable(amps_milli) && $stable(watts_deci) && $stable(energy_mwh)
			&& $stable(report_now) && $stable(save_now))
		else $error("stalled result changed");

	// Never present a result without an item in flight
	a_no_invent: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> inflight_q != 3'd0)
		else $error("result without a pending reading");

	// At most four items in flight, and input backpressure only when all are taken
	a_capacity: assert property (@(posedge clk) disable iff (!arst_n)
		inflight_q <= 3'd4)
		else $error("more than four items in flight");

	a_ready_full: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> inflight_q == 3'd4 && out_valid && !out_ready)
		else $error("input stalled with free pipeline space");

	// The energy total grows by at most one second's increment per result
	a_energy_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && seen_q |-> e_step <= EINC_MAX)
		else $error("energy total jumped");

endmodule

bind energy_meter_report_scheduler_unit emrs_checker u_emrs_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (reading.valid),
	.in_ready   (reading.ready),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.volts_deci (result.volts_deci),
	.amps_milli (result.amps_milli),
	.watts_deci (result.watts_deci),
	.energy_mwh (result.energy_mwh),
	.report_now (result.report_now),
	.save_now   (result.save_now)
);
